### hdl/assert_macros.svh
// Assertion macros shared by the pixel writer RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Delayed form of the implication check: the consequent must hold later than the antecedent.
`define ASSERT_DELAY2(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##2 (cons)) \
		else $error("two-cycle latency check failed");

`endif

### hdl/rgbpw_pkg.sv
// Package for the RGB pixel writer: configuration types, register codes and
// the channel packing helpers. Depends on nothing.
package rgbpw_pkg;

	// Size of the back buffer in bytes; a power of two so addresses wrap by masking.
	localparam int unsigned BufferBytes = 8388608;
	localparam int unsigned AddrW = $clog2(BufferBytes);

	localparam int unsigned CoordW = 12;
	localparam int unsigned PitchW = 14;
	localparam int unsigned LayoutW = 9;
	localparam int unsigned ChanW = 8;
	localparam int unsigned WordW = 32;
	localparam int unsigned CfgDataW = 14;
	localparam int unsigned CfgIdxW = 3;

	// Register indexes of the configuration port.
	typedef enum logic [CfgIdxW-1:0] {
		REG_ENABLED = 3'd0,
		REG_WIDTH = 3'd1,
		REG_HEIGHT = 3'd2,
		REG_ROW_PITCH = 3'd3,
		REG_PIXEL_FORMAT = 3'd4,
		REG_RED_LAYOUT = 3'd5,
		REG_GREEN_LAYOUT = 3'd6,
		REG_BLUE_LAYOUT = 3'd7
	} cfg_idx_t;

	// Pixel formats.
	typedef enum logic [1:0] {
		FMT_15BPP = 2'd0,
		FMT_16BPP = 2'd1,
		FMT_24BPP = 2'd2,
		FMT_32BPP = 2'd3
	} pix_fmt_t;

	// Live configuration as seen by the datapath.
	typedef struct packed {
		logic enabled;
		logic [CoordW-1:0] width;
		logic [CoordW-1:0] height;
		logic [PitchW-1:0] row_pitch;
		pix_fmt_t pixel_format;
		logic [LayoutW-1:0] red_layout;
		logic [LayoutW-1:0] green_layout;
		logic [LayoutW-1:0] blue_layout;
	} cfg_t;

	// Cut a channel to its mask size and move it to its field position.
	function automatic logic [WordW-1:0] place_channel(input logic [ChanW-1:0] level,
			input logic [LayoutW-1:0] layout);
		logic [3:0] size;
		logic [4:0] pos;
		logic [ChanW-1:0] cut;
		logic [WordW+ChanW-2:0] wide;
		size = layout[3:0];
		pos = layout[8:4];
		if (size < 4'd8) begin
			cut = level >> (4'd8 - size);
		end else begin
			cut = level;
		end
		wide = {{(WordW-1){1'b0}}, cut} << pos;
		return wide[WordW-1:0];
	endfunction

	// Bytes stored per pixel.
	function automatic logic [2:0] fmt_bytes(input pix_fmt_t fmt);
		logic [2:0] n;
		case (fmt)
			FMT_24BPP: n = 3'd3;
			FMT_32BPP: n = 3'd4;
			default: n = 3'd2;
		endcase
		return n;
	endfunction

	// Mask that keeps the bytes a pixel actually occupies.
	function automatic logic [WordW-1:0] data_mask(input pix_fmt_t fmt);
		logic [WordW-1:0] m;
		case (fmt)
			FMT_24BPP: m = 32'h00FF_FFFF;
			FMT_32BPP: m = 32'hFFFF_FFFF;
			default: m = 32'h0000_FFFF;
		endcase
		return m;
	endfunction

endpackage

### hdl/rgbpw_cfg_regs.sv
// Configuration register file of the pixel writer.
// Depends on rgbpw_pkg for the register codes and the cfg_t struct.
module rgbpw_cfg_regs (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [rgbpw_pkg::CfgIdxW-1:0] cfg_index,
	input logic [rgbpw_pkg::CfgDataW-1:0] cfg_data,
	output rgbpw_pkg::cfg_t cfg
);
	import rgbpw_pkg::*;

	cfg_t cfg_q;

	// Each register takes the low bits of the written word at its index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_ENABLED: cfg_q.enabled <= cfg_data[0];
				REG_WIDTH: cfg_q.width <= cfg_data[CoordW-1:0];
				REG_HEIGHT: cfg_q.height <= cfg_data[CoordW-1:0];
				REG_ROW_PITCH: cfg_q.row_pitch <= cfg_data[PitchW-1:0];
				REG_PIXEL_FORMAT: cfg_q.pixel_format <= pix_fmt_t'(cfg_data[1:0]);
				REG_RED_LAYOUT: cfg_q.red_layout <= cfg_data[LayoutW-1:0];
				REG_GREEN_LAYOUT: cfg_q.green_layout <= cfg_data[LayoutW-1:0];
				REG_BLUE_LAYOUT: cfg_q.blue_layout <= cfg_data[LayoutW-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/rgb_pixel_writer_top.sv
// Top level of the RGB pixel writer: input register, packing and address
// logic, result register. Depends on rgbpw_pkg, rgbpw_cfg_regs, assert_macros.svh.
//
// Channel   Handshake               Payload
// input     start, busy             pos_x, pos_y, red_in, green_in, blue_in
// result    done (one-cycle strobe) write_enable, byte_address, pixel_data, byte_count
// config    cfg_we                  cfg_index, cfg_data
//
// A pixel word is taken at every edge where start is high; busy is always low.
// Each result is strobed by done once its word has passed the input register and the result register.
// The rate is one word per clock, since no stage ever stalls.
// Reset clears the configuration and the valid bits; the receiver cannot stall.
`include "assert_macros.svh"

module rgb_pixel_writer_top (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [rgbpw_pkg::CoordW-1:0] pos_x,
	input logic [rgbpw_pkg::CoordW-1:0] pos_y,
	input logic [rgbpw_pkg::ChanW-1:0] red_in,
	input logic [rgbpw_pkg::ChanW-1:0] green_in,
	input logic [rgbpw_pkg::ChanW-1:0] blue_in,
	input logic cfg_we,
	input logic [rgbpw_pkg::CfgIdxW-1:0] cfg_index,
	input logic [rgbpw_pkg::CfgDataW-1:0] cfg_data,
	output logic done,
	output logic write_enable,
	output logic [rgbpw_pkg::AddrW-1:0] byte_address,
	output logic [rgbpw_pkg::WordW-1:0] pixel_data,
	output logic [2:0] byte_count
);
	import rgbpw_pkg::*;

	localparam int unsigned RowOffW = CoordW + PitchW;
	localparam int unsigned SumW = RowOffW + 1;

	cfg_t cfg;

	logic valid_s1;
	logic [CoordW-1:0] pos_x_s1;
	logic [CoordW-1:0] pos_y_s1;
	logic [ChanW-1:0] red_s1;
	logic [ChanW-1:0] green_s1;
	logic [ChanW-1:0] blue_s1;

	logic [2:0] bpp;
	logic in_bounds;
	logic [RowOffW-1:0] row_off;
	logic [RowOffW-1:0] col_off;
	logic [SumW-1:0] addr_sum;
	logic [WordW-1:0] packed_word;

	logic valid_s2;
	logic we_s2;
	logic [AddrW-1:0] addr_s2;
	logic [WordW-1:0] data_s2;
	logic [2:0] count_s2;

	rgbpw_cfg_regs u_cfg_regs (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	// A new word can enter every cycle.
	assign busy = 1'b0;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pos_x_s1 <= pos_x;
			pos_y_s1 <= pos_y;
			red_s1 <= red_in;
			green_s1 <= green_in;
			blue_s1 <= blue_in;
		end
	end

	// Bounds check, byte address and packed color.
	always_comb begin
		bpp = fmt_bytes(cfg.pixel_format);
		in_bounds = cfg.enabled && (pos_x_s1 < cfg.width) && (pos_y_s1 < cfg.height);
		row_off = RowOffW'(pos_y_s1) * RowOffW'(cfg.row_pitch);
		col_off = RowOffW'(pos_x_s1) * RowOffW'(bpp);
		addr_sum = SumW'(row_off) + SumW'(col_off);
		packed_word = place_channel(red_s1, cfg.red_layout)
			| place_channel(green_s1, cfg.green_layout)
			| place_channel(blue_s1, cfg.blue_layout);
	end

	// Result register; a blocked write reports zero address and data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			we_s2 <= in_bounds;
			addr_s2 <= in_bounds ? addr_sum[AddrW-1:0] : '0;
			data_s2 <= in_bounds ? (packed_word & data_mask(cfg.pixel_format)) : '0;
			count_s2 <= bpp;
		end
	end

	assign done = valid_s2;
	assign write_enable = valid_s2 & we_s2;
	assign byte_address = valid_s2 ? addr_s2 : '0;
	assign pixel_data = valid_s2 ? data_s2 : '0;
	assign byte_count = valid_s2 ? count_s2 : 3'd0;

	// Every accepted word yields a result after the input and result registers.
	`ASSERT_DELAY2(a_word_to_result, clk, arst_n, start && !busy, done)
	// An enabled write was computed while the block was enabled.
	`ASSERT_IMPLIES(a_we_needs_enable, clk, arst_n, write_enable, $past(cfg.enabled))
	// Nothing is written outside a result cycle.
	`ASSERT_IMPLIES(a_we_in_result, clk, arst_n, write_enable, done)
	// A valid result always carries a real byte count.
	`ASSERT_IMPLIES(a_count_legal, clk, arst_n, done, byte_count >= 3'd2 && byte_count <= 3'd4)

endmodule
